// ----- src/double_array_trie_lookup_defines.svh -----
// Assertion macros for the checker file of the trie lookup block.
`ifndef DOUBLE_ARRAY_TRIE_LOOKUP_DEFINES_SVH
`define DOUBLE_ARRAY_TRIE_LOOKUP_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define DATL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define DATL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/datl_pkg.sv -----
// Types and constants of the double-array trie lookup block.
`default_nettype none
package datl_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 10;
    localparam int BASE_W     = 10;
    localparam int CHECK_W    = 11;
    localparam int LETTER_W   = 5;
    localparam int NODE_OUT_W = 10;
    localparam int WORD_W     = BASE_W + CHECK_W;
    localparam int SUM_W      = BASE_W + 1;
    localparam int ROOT_NODE  = 1;

    // Table word after reset at the root entry: base zero, check minus one.
    localparam logic [WORD_W-1:0] ROOT_WORD = {{BASE_W{1'b0}}, {CHECK_W{1'b1}}};

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_QUERY = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BASE,
        ST_CHECK
    } state_t;

endpackage
`default_nettype wire

// ----- src/datl_if.sv -----
// Request and response channel interfaces of the trie lookup block.
`default_nettype none
interface datl_req_if
    import datl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [IDX_W-1:0]           entry_index;
    logic [BASE_W-1:0]          base_value;
    logic signed [CHECK_W-1:0]  check_value;
    logic [LETTER_W-1:0]        letter;
    logic                       last_letter;

    modport source (
        output valid, operation, entry_index, base_value, check_value, letter, last_letter,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, base_value, check_value, letter, last_letter,
        output ready
    );
endinterface

interface datl_rsp_if
    import datl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [NODE_OUT_W-1:0]  end_node;

    modport source (
        output valid, found, end_node,
        input  ready
    );
    modport sink (
        input  valid, found, end_node,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/datl_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module datl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/double_array_trie_lookup.sv -----
// Double-array trie lookup: base and check tables in one RAM, walked one letter per item.
// A query letter makes two dependent RAM reads, base then check, and resolves in ST_CHECK;
// the next item is taken as the check data returns, unless the output is stalled. Letters
// after a failed step read no RAM. A last letter holds off input until its result is
// registered. After reset a clearing pass writes every table entry and loads the root word,
// with ready held low. Results leave through an output register.
`default_nettype none
module double_array_trie_lookup
    import datl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input wire logic  clk,
    input wire logic  rst_n,
    datl_req_if.sink  req,
    datl_rsp_if.source rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    state_t                 state_reg, state_next;
    logic [AW-1:0]          node_reg, node_next;
    logic                   failed_reg, failed_next;
    logic                   flag_reg, flag_next;
    logic                   root_flag_reg, root_flag_next;
    logic                   last_reg, last_next;
    logic [LETTER_W-1:0]    letter_reg, letter_next;
    logic [AW-1:0]          target_reg, target_next;
    logic                   oob_reg, oob_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [NODE_OUT_W-1:0]  end_node_reg, end_node_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    logic                   out_free;
    logic                   req_ready;
    logic [CHECK_W-1:0]     chk;
    logic [CHECK_W-1:0]     mag;
    logic                   step_ok;
    logic [AW-1:0]          res_node;
    logic                   res_failed;
    logic                   res_flag;
    logic [AW-1:0]          eff_node;
    logic                   eff_failed;
    logic                   eff_flag;
    logic [SUM_W-1:0]       sum;

    datl_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_ready = ((state_reg == ST_IDLE) || ((state_reg == ST_CHECK) && !last_reg))
                       && out_free;
    assign req.ready = req_ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = found_reg;
    assign rsp.end_node = end_node_reg;

    // The check data of the step in flight resolves the walk in the cycle it returns.
    assign chk        = ram_rdata[CHECK_W-1:0];
    assign mag        = chk[CHECK_W-1] ? (~chk + CHECK_W'(1)) : chk;
    assign step_ok    = !oob_reg && (32'(mag) == 32'(node_reg));
    assign res_node   = step_ok ? target_reg : node_reg;
    assign res_failed = !step_ok;
    assign res_flag   = step_ok ? chk[CHECK_W-1] : flag_reg;

    assign eff_node   = (state_reg == ST_CHECK) ? res_node : node_reg;
    assign eff_failed = (state_reg == ST_CHECK) ? res_failed : failed_reg;
    assign eff_flag   = (state_reg == ST_CHECK) ? res_flag : flag_reg;

    assign sum = {1'b0, ram_rdata[WORD_W-1:CHECK_W]}
                 + {{(SUM_W-LETTER_W){1'b0}}, letter_reg};

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        failed_next    = failed_reg;
        flag_next      = flag_reg;
        root_flag_next = root_flag_reg;
        last_next      = last_reg;
        letter_next    = letter_reg;
        target_next    = target_reg;
        oob_next       = oob_reg;
        clr_next       = clr_reg;
        found_next     = found_reg;
        end_node_next  = end_node_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = node_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == AW'(ROOT_NODE)) ? ROOT_WORD : '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_BASE:
            begin
                ram_re      = 1'b1;
                ram_raddr   = AW'(sum);
                target_next = AW'(sum);
                oob_next    = 32'(sum) >= TABLE_DEPTH;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (last_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = !res_failed && res_flag;
                        end_node_next  = NODE_OUT_W'(res_node);
                        node_next      = AW'(ROOT_NODE);
                        failed_next    = 1'b0;
                        flag_next      = root_flag_reg;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    node_next   = res_node;
                    failed_next = res_failed;
                    flag_next   = res_flag;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (req.valid && req_ready)
        begin
            case (req.operation)
                OP_WRITE:
                begin
                    if (32'(req.entry_index) < TABLE_DEPTH)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(req.entry_index);
                        ram_wdata = {req.base_value, req.check_value};
                        if (32'(req.entry_index) == 32'(eff_node))
                        begin
                            flag_next = req.check_value[CHECK_W-1];
                        end
                        if (32'(req.entry_index) == ROOT_NODE)
                        begin
                            root_flag_next = req.check_value[CHECK_W-1];
                        end
                    end
                end
                OP_QUERY:
                begin
                    letter_next = req.letter;
                    last_next   = req.last_letter;
                    if (eff_failed)
                    begin
                        if (req.last_letter)
                        begin
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                            end_node_next  = NODE_OUT_W'(eff_node);
                            node_next      = AW'(ROOT_NODE);
                            failed_next    = 1'b0;
                            flag_next      = root_flag_reg;
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = eff_node;
                        state_next = ST_BASE;
                    end
                end
                OP_END:
                begin
                    out_valid_next = 1'b1;
                    found_next     = !eff_failed && eff_flag;
                    end_node_next  = NODE_OUT_W'(eff_node);
                    node_next      = AW'(ROOT_NODE);
                    failed_next    = 1'b0;
                    flag_next      = root_flag_reg;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            node_reg      <= AW'(ROOT_NODE);
            failed_reg    <= 1'b0;
            flag_reg      <= 1'b1;
            root_flag_reg <= 1'b1;
            last_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            failed_reg    <= failed_next;
            flag_reg      <= flag_next;
            root_flag_reg <= root_flag_next;
            last_reg      <= last_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg   <= letter_next;
        target_reg   <= target_next;
        oob_reg      <= oob_next;
        found_reg    <= found_next;
        end_node_reg <= end_node_next;
    end

endmodule
`default_nettype wire

// ----- src/datl_chk.sv -----
// Port-level assertion checker for the trie lookup block, with its bind statement.
`default_nettype none
`include "double_array_trie_lookup_defines.svh"
module datl_chk
    import datl_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  req_valid,
    input wire logic                  req_ready,
    input wire logic [OP_W-1:0]       req_operation,
    input wire logic                  rsp_valid,
    input wire logic                  rsp_ready,
    input wire logic                  rsp_found,
    input wire logic [NODE_OUT_W-1:0] rsp_end_node
);

    logic req_end;

    assign req_end = req_valid && req_ready && (req_operation == OP_END);

    // A stalled result keeps its values until its transfer.
    `DATL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_end_node), "result changed while stalled")

    // An end item gives its result in the next cycle.
    `DATL_ASSERT_NEXT(a_end_result, clk, rst_n, req_end, rsp_valid, "end item gave no result")

    // A table write never causes a result.
    `DATL_ASSERT_NEXT(a_write_silent, clk, rst_n, req_valid && req_ready && (req_operation == OP_WRITE), !$rose(rsp_valid), "table write caused a result")

    // Two end items in a row: the second one ends at the root.
    `DATL_ASSERT(a_end_root, clk, rst_n, req_end ##1 req_end |=> (rsp_end_node == NODE_OUT_W'(ROOT_NODE)), "second empty word did not end at the root")

endmodule

bind double_array_trie_lookup datl_chk u_datl_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_operation(req.operation),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_found    (rsp.found),
    .rsp_end_node (rsp.end_node)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench that walks random tries through the double-array trie lookup block.
`default_nettype none
module tb_top;
    import datl_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AFTER = 150;
    localparam int PHASES = 3;
    localparam int WORDS_PER_PHASE = 35;
    localparam int QUERIES_PER_PHASE = 120;

    typedef struct {
        logic [OP_W-1:0]           operation;
        logic [IDX_W-1:0]          entry_index;
        logic [BASE_W-1:0]         base_value;
        logic signed [CHECK_W-1:0] check_value;
        logic [LETTER_W-1:0]       letter;
        logic                      last_letter;
    } trie_item_t;

    typedef struct {
        logic                  found;
        logic [NODE_OUT_W-1:0] end_node;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n;

    datl_req_if req ();
    datl_rsp_if rsp ();

    double_array_trie_lookup #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    trie_item_t     pending_q[$];
    lookup_result_t lookup_q[$];

    logic [BASE_W-1:0]         trie_base[DEPTH];
    logic signed [CHECK_W-1:0] trie_check[DEPTH];
    int                        walk_node;
    bit                        walk_failed;

    int plan_base[DEPTH];
    int plan_check[DEPTH];
    bit slot_taken[DEPTH];
    bit has_children[DEPTH];

    bit req_taken = 1'b0;
    bit rsp_taken = 1'b0;
    bit req_burst = 1'b0;
    bit rsp_burst = 1'b0;
    bit hold_done = 1'b0;
    int req_gap = 0;
    int rsp_gap = 0;
    int hold_left = 0;
    int results_seen = 0;
    int mismatch_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int mag_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int pick_gap(input bit burst);
        int roll;
        roll = $urandom_range(99);
        if (burst || roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic trie_item_t random_item(input logic [OP_W-1:0] op);
        trie_item_t it;
        it.operation   = op;
        it.entry_index = IDX_W'($urandom);
        it.base_value  = BASE_W'($urandom);
        it.check_value = CHECK_W'($urandom);
        it.letter      = LETTER_W'($urandom);
        it.last_letter = 1'($urandom);
        return it;
    endfunction

    task automatic queue_write(input int idx, input int base_v, input int chk);
        trie_item_t it;
        it = random_item(OP_WRITE);
        it.entry_index = IDX_W'(idx);
        it.base_value  = BASE_W'(base_v);
        it.check_value = CHECK_W'(chk);
        plan_base[idx]  = base_v;
        plan_check[idx] = chk;
        pending_q.push_back(it);
    endtask

    task automatic queue_letter(input int ltr, input bit last);
        trie_item_t it;
        it = random_item(OP_QUERY);
        it.letter      = LETTER_W'(ltr);
        it.last_letter = last;
        pending_q.push_back(it);
    endtask

    task automatic queue_end();
        pending_q.push_back(random_item(OP_END));
    endtask

    task automatic queue_unused();
        pending_q.push_back(random_item(OP_UNUSED));
    endtask

    task automatic insert_word(input int len);
        int node;
        int ltr;
        int child;
        int b;
        int tries;
        bit placed;
        node = ROOT_NODE;
        for (int i = 0; i < len; i++)
        begin
            ltr = $urandom_range(25);
            child = plan_base[node] + ltr;
            if (has_children[node] && child < DEPTH && mag_of(plan_check[child]) == node)
            begin
                slot_taken[child] = 1'b1;
                node = child;
            end
            else
            begin
                if (!has_children[node])
                begin
                    placed = 1'b0;
                    b = 0;
                    for (tries = 0; tries < 24 && !placed; tries++)
                    begin
                        b = $urandom_range(DEPTH - 1);
                        if (b + ltr < DEPTH && !slot_taken[b + ltr])
                        begin
                            placed = 1'b1;
                        end
                    end
                    if (!placed)
                    begin
                        break;
                    end
                    has_children[node] = 1'b1;
                    queue_write(node, b, plan_check[node]);
                    child = b + ltr;
                end
                else if (child >= DEPTH || slot_taken[child])
                begin
                    break;
                end
                slot_taken[child] = 1'b1;
                has_children[child] = 1'b0;
                queue_write(child, 0, node);
                node = child;
            end
        end
        if (node != ROOT_NODE)
        begin
            queue_write(node, plan_base[node], -mag_of(plan_check[node]));
        end
    endtask

    task automatic query_word();
        int len;
        int node;
        int ltr;
        int child;
        bit broken;
        bit end_by_item;
        int choices[$];
        if ($urandom_range(99) < 8)
        begin
            queue_end();
            return;
        end
        len = $urandom_range(7, 1);
        end_by_item = ($urandom_range(99) < 15);
        node = ROOT_NODE;
        broken = 1'b0;
        for (int i = 0; i < len; i++)
        begin
            choices.delete();
            if (!broken)
            begin
                for (int l = 0; l < 32; l++)
                begin
                    child = plan_base[node] + l;
                    if (child < DEPTH && mag_of(plan_check[child]) == node)
                    begin
                        choices.push_back(l);
                    end
                end
            end
            if (choices.size() > 0 && $urandom_range(99) < 88)
            begin
                ltr = choices[$urandom_range(choices.size() - 1)];
            end
            else
            begin
                ltr = $urandom_range(31);
            end
            if (!broken)
            begin
                child = plan_base[node] + ltr;
                if (child >= DEPTH)
                begin
                    broken = 1'b1;
                end
                else if (mag_of(plan_check[child]) != node)
                begin
                    broken = 1'b1;
                end
                else
                begin
                    node = child;
                end
            end
            queue_letter(ltr, (i == len - 1) && !end_by_item);
        end
        if (end_by_item)
        begin
            queue_end();
        end
    endtask

    task automatic finish_lookup();
        lookup_result_t res;
        res.found    = !walk_failed && trie_check[walk_node][CHECK_W-1];
        res.end_node = NODE_OUT_W'(walk_node);
        lookup_q.push_back(res);
        walk_node   = ROOT_NODE;
        walk_failed = 1'b0;
    endtask

    task automatic trie_step(input trie_item_t it);
        int step_node;
        case (it.operation)
            OP_WRITE:
            begin
                trie_base[it.entry_index]  = it.base_value;
                trie_check[it.entry_index] = it.check_value;
            end
            OP_QUERY:
            begin
                if (!walk_failed)
                begin
                    step_node = int'(trie_base[walk_node]) + int'(it.letter);
                    if (step_node >= DEPTH)
                    begin
                        walk_failed = 1'b1;
                    end
                    else if (mag_of(int'(trie_check[step_node])) != walk_node)
                    begin
                        walk_failed = 1'b1;
                    end
                    else
                    begin
                        walk_node = step_node;
                    end
                end
                if (it.last_letter)
                begin
                    finish_lookup();
                end
            end
            OP_END:
            begin
                finish_lookup();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    task automatic drain_all();
        while (pending_q.size() != 0 || req.valid || lookup_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        bit keep;
        trie_item_t it;
        keep = req.valid && !req_taken;
        req_taken = 1'b0;
        if (rst_n && !keep)
        begin
            if (req_gap > 0)
            begin
                req_gap--;
            end
            else if (pending_q.size() != 0)
            begin
                it = pending_q.pop_front();
                req.operation   <= it.operation;
                req.entry_index <= it.entry_index;
                req.base_value  <= it.base_value;
                req.check_value <= it.check_value;
                req.letter      <= it.letter;
                req.last_letter <= it.last_letter;
                keep = 1'b1;
                req_gap = pick_gap(req_burst);
                if ($urandom_range(149) == 0)
                begin
                    req_burst = !req_burst;
                end
            end
        end
        req.valid <= keep;
    end

    always @(negedge clk)
    begin
        bit rdy;
        if (rsp_taken)
        begin
            rsp_gap = pick_gap(rsp_burst);
            if ($urandom_range(99) == 0)
            begin
                rsp_burst = !rsp_burst;
            end
        end
        rsp_taken = 1'b0;
        if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rdy = 1'b0;
        end
        else
        begin
            rdy = 1'b1;
        end
        rsp.ready <= rdy;
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        trie_item_t it;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsp_taken = 1'b1;
                results_seen++;
                if (lookup_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with none expected, actual found %0d end_node %0d",
                             $time, rsp.found, rsp.end_node);
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        report_mismatch("found", want.found, rsp.found);
                    end
                    if (rsp.end_node !== want.end_node)
                    begin
                        report_mismatch("end_node", want.end_node, rsp.end_node);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                req_taken = 1'b1;
                it.operation   = req.operation;
                it.entry_index = req.entry_index;
                it.base_value  = req.base_value;
                it.check_value = req.check_value;
                it.letter      = req.letter;
                it.last_letter = req.last_letter;
                trie_step(it);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int roll;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_WRITE;
        req.entry_index = '0;
        req.base_value = '0;
        req.check_value = '0;
        req.letter = '0;
        req.last_letter = 1'b0;
        rsp.ready = 1'b0;
        for (int s = 0; s < DEPTH; s++)
        begin
            trie_base[s] = '0;
            trie_check[s] = '0;
            plan_base[s] = 0;
            plan_check[s] = 0;
        end
        trie_check[ROOT_NODE] = -1;
        plan_check[ROOT_NODE] = -1;
        walk_node = ROOT_NODE;
        walk_failed = 1'b0;

        // Edge cases: table edges, the most negative check, letters past the alphabet.
        queue_end();
        queue_letter(0, 1'b1);
        queue_unused();
        queue_write(ROOT_NODE, 1000, -1);
        queue_write(1005, 1023, 1);
        queue_write(1023, 0, -1005);
        queue_write(1010, 682, -1024);
        queue_letter(5, 1'b0);
        queue_letter(0, 1'b1);
        queue_letter(5, 1'b0);
        queue_letter(31, 1'b1);
        queue_letter(10, 1'b1);
        queue_letter(31, 1'b0);
        queue_letter(5, 1'b0);
        queue_letter(0, 1'b1);
        queue_letter(5, 1'b0);
        queue_end();
        queue_write(0, 341, 1023);
        queue_end();
        queue_write(ROOT_NODE, 0, 1);
        queue_end();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        drain_all();

        for (int p = 0; p < PHASES; p++)
        begin
            for (int s = 0; s < DEPTH; s++)
            begin
                slot_taken[s] = 1'b0;
                has_children[s] = 1'b0;
            end
            slot_taken[0] = 1'b1;
            slot_taken[ROOT_NODE] = 1'b1;
            queue_write(ROOT_NODE, 0, ($urandom_range(1) != 0) ? -1 : 1);
            repeat (WORDS_PER_PHASE) insert_word($urandom_range(5, 1));
            for (int q = 0; q < QUERIES_PER_PHASE; q++)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    queue_write($urandom_range(DEPTH - 1), $urandom_range(DEPTH - 1),
                                int'($urandom_range(2047)) - 1024);
                end
                else if (roll < 11)
                begin
                    queue_unused();
                end
                else
                begin
                    query_word();
                end
            end
            drain_all();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && lookup_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+src
src/datl_pkg.sv
src/datl_if.sv
src/datl_ram.sv
src/double_array_trie_lookup.sv
src/datl_chk.sv
verif/tb_top.sv
